### rtl/lpb_pkg.sv
// Package with widths, fixed-point constants, coefficient tables and helpers for the basis unit.
package lpb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 20;
    localparam int VAL_W      = 48;
    localparam int ORDER_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ORDER_W;
    localparam int HALF_W     = VAL_W / 2;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int MAG_W      = PROD_W - FRAC_BITS;
    localparam int N_STEPS    = 3;
    localparam int N_MUL_W    = 2;
    localparam int FMUL_LAT   = 3;
    localparam int LANE_LAT   = (N_STEPS + 3) * FMUL_LAT + N_STEPS + 2;
    localparam int X_TAPS     = LANE_LAT - 1;
    localparam int XMUL_TAP   = (N_STEPS + 1) * (FMUL_LAT + 1) - 1;
    localparam int MERGE_LAT  = 2 * FMUL_LAT;
    localparam int PIPE_DEPTH = LANE_LAT + MERGE_LAT;

    typedef logic signed [VAL_W-1:0] t_val;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_Z = CFG_IDX_W'(2);

    localparam longint ONE_L = longint'(1) << FRAC_BITS;

    localparam t_val VAL_ONE = t_val'(ONE_L);
    localparam t_val VAL_MAX = t_val'((longint'(1) << (VAL_W - 1)) - 1);
    localparam t_val VAL_MIN = t_val'(-(longint'(1) << (VAL_W - 1)));

    localparam logic [PROD_W-1:0] FM_RND     = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [MAG_W-1:0]  FM_MAG_LIM = MAG_W'(1) << (VAL_W - 1);

    // Decimal constants rounded to nearest at FRAC_BITS fraction bits.
    localparam t_val C2_A = t_val'((3333333 * ONE_L * 2 + 10000000) / (2 * 10000000));
    localparam t_val C3_A = t_val'((6 * ONE_L * 2 + 10) / (2 * 10));
    localparam t_val C3_S = t_val'((3 * ONE_L * 2 + 2) / (2 * 2));
    localparam t_val C4_A = t_val'((857143 * ONE_L * 2 + 1000000) / (2 * 1000000));
    localparam t_val C4_B = t_val'((857143 * ONE_L * 2 + 10000000) / (2 * 10000000));
    localparam t_val C5_A = t_val'((111111 * ONE_L * 2 + 100000) / (2 * 100000));
    localparam t_val C5_B = t_val'((238095 * ONE_L * 2 + 1000000) / (2 * 1000000));
    localparam t_val C6_A = t_val'((136364 * ONE_L * 2 + 100000) / (2 * 100000));
    localparam t_val C6_B = t_val'((454545 * ONE_L * 2 + 1000000) / (2 * 1000000));
    localparam t_val C6_C = t_val'((21645 * ONE_L * 2 + 1000000) / (2 * 1000000));
    localparam t_val C7_A = t_val'((161538 * ONE_L * 2 + 100000) / (2 * 100000));
    localparam t_val C7_B = t_val'((734266 * ONE_L * 2 + 1000000) / (2 * 1000000));
    localparam t_val C7_C = t_val'((81585 * ONE_L * 2 + 1000000) / (2 * 1000000));
    localparam t_val C8_A = t_val'((186667 * ONE_L * 2 + 100000) / (2 * 100000));
    localparam t_val C8_B = t_val'((107692 * ONE_L * 2 + 100000) / (2 * 100000));
    localparam t_val C8_C = t_val'((195804 * ONE_L * 2 + 1000000) / (2 * 1000000));
    localparam t_val C8_D = t_val'((54390 * ONE_L * 2 + 10000000) / (2 * 10000000));
    localparam t_val C9_A = t_val'((211765 * ONE_L * 2 + 100000) / (2 * 100000));
    localparam t_val C9_B = t_val'((148235 * ONE_L * 2 + 100000) / (2 * 100000));
    localparam t_val C9_C = t_val'((380090 * ONE_L * 2 + 1000000) / (2 * 1000000));
    localparam t_val C9_D = t_val'((259153 * ONE_L * 2 + 10000000) / (2 * 10000000));

    typedef enum logic [1:0] {
        KIND_ONE  = 2'd0,
        KIND_LIN  = 2'd1,
        KIND_POLY = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        t_val                     k0;
        t_val [N_STEPS-1:0]       k;
        logic [N_MUL_W-1:0]       nmul;
        logic                     odd;
        t_val                     scale;
    } t_coef;

    function automatic t_val sat_add(t_val a, t_val b);
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        return t_val'(s[VAL_W-1:0]);
    endfunction

    function automatic t_coef get_coef(logic [ORDER_W-1:0] order);
        t_coef c;
        c.kind  = KIND_POLY;
        c.k0    = '0;
        c.k     = '0;
        c.nmul  = '0;
        c.odd   = 1'b0;
        c.scale = VAL_ONE;
        unique case (order)
            4'd1: begin
                c.kind = KIND_LIN;
            end
            4'd2: begin
                c.k0 = -C2_A;
            end
            4'd3: begin
                c.k0    = -C3_A;
                c.odd   = 1'b1;
                c.scale = C3_S;
            end
            4'd4: begin
                c.k0    = -C4_A;
                c.nmul  = N_MUL_W'(1);
                c.k[0]  = C4_B;
                c.scale = t_val'(2 * ONE_L);
            end
            4'd5: begin
                c.k0    = -C5_A;
                c.nmul  = N_MUL_W'(1);
                c.k[0]  = C5_B;
                c.odd   = 1'b1;
                c.scale = t_val'(3 * ONE_L);
            end
            4'd6: begin
                c.k0    = -C6_A;
                c.nmul  = N_MUL_W'(2);
                c.k[0]  = C6_B;
                c.k[1]  = -C6_C;
                c.scale = t_val'(6 * ONE_L);
            end
            4'd7: begin
                c.k0    = -C7_A;
                c.nmul  = N_MUL_W'(2);
                c.k[0]  = C7_B;
                c.k[1]  = -C7_C;
                c.odd   = 1'b1;
                c.scale = t_val'(10 * ONE_L);
            end
            4'd8: begin
                c.k0    = -C8_A;
                c.nmul  = N_MUL_W'(3);
                c.k[0]  = C8_B;
                c.k[1]  = -C8_C;
                c.k[2]  = C8_D;
                c.scale = t_val'(18 * ONE_L);
            end
            4'd9: begin
                c.k0    = -C9_A;
                c.nmul  = N_MUL_W'(3);
                c.k[0]  = C9_B;
                c.k[1]  = -C9_C;
                c.k[2]  = C9_D;
                c.odd   = 1'b1;
                c.scale = t_val'(32 * ONE_L);
            end
            default: begin
                c.kind = KIND_ONE;
            end
        endcase
        return c;
    endfunction

endpackage

### rtl/lpb_in_if.sv
// Input channel interface carrying one coordinate triple per beat.
interface lpb_in_if;
    import lpb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_in;

    modport source (output valid, coord_x, coord_y, coord_z, last_in, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, last_in, output ready);
endinterface

### rtl/lpb_out_if.sv
// Output channel interface carrying one basis value per beat.
interface lpb_out_if;
    import lpb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] basis_value;
    logic                    last_out;

    modport source (output valid, basis_value, last_out, input ready);
    modport sink   (input valid, basis_value, last_out, output ready);
endinterface

### rtl/lpb_fmul.sv
// Three-stage rounded, saturating signed fixed-point multiplier built from 24x24 partial products.
module lpb_fmul (
    input  logic          i_clk,
    input  logic          i_en,
    input  lpb_pkg::t_val i_a,
    input  lpb_pkg::t_val i_b,
    output lpb_pkg::t_val o_p
);
    import lpb_pkg::*;

    logic [VAL_W-1:0]  w_ua;
    logic [VAL_W-1:0]  w_ub;
    logic [VAL_W-1:0]  w_ma;
    logic [VAL_W-1:0]  w_mb;
    logic [VAL_W-1:0]  r_ll;
    logic [VAL_W-1:0]  r_lh;
    logic [VAL_W-1:0]  r_hl;
    logic [VAL_W-1:0]  r_hh;
    logic              r_neg1;
    logic              r_neg2;
    logic [VAL_W:0]    w_mid;
    logic [PROD_W-1:0] w_full;
    logic [MAG_W-1:0]  r_mag;
    logic [MAG_W-1:0]  w_lim;
    logic [VAL_W-1:0]  w_m;
    t_val              n_p;
    t_val              r_p;

    assign w_ua = i_a;
    assign w_ub = i_b;
    assign w_ma = w_ua[VAL_W-1] ? (~w_ua + VAL_W'(1)) : w_ua;
    assign w_mb = w_ub[VAL_W-1] ? (~w_ub + VAL_W'(1)) : w_ub;

    assign w_mid  = {1'b0, r_lh} + {1'b0, r_hl};
    assign w_full = {r_hh, {VAL_W{1'b0}}}
                  + {{(HALF_W - 1){1'b0}}, w_mid, {HALF_W{1'b0}}}
                  + {{VAL_W{1'b0}}, r_ll}
                  + FM_RND;

    assign w_lim = (r_mag > FM_MAG_LIM) ? FM_MAG_LIM : r_mag;
    assign w_m   = w_lim[VAL_W-1:0];

    always_comb begin
        if (r_neg2) begin
            n_p = t_val'(~w_m + VAL_W'(1));
        end else if (w_m[VAL_W-1]) begin
            n_p = VAL_MAX;
        end else begin
            n_p = t_val'(w_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll   <= w_ma[HALF_W-1:0] * w_mb[HALF_W-1:0];
            r_lh   <= w_ma[HALF_W-1:0] * w_mb[VAL_W-1:HALF_W];
            r_hl   <= w_ma[VAL_W-1:HALF_W] * w_mb[HALF_W-1:0];
            r_hh   <= w_ma[VAL_W-1:HALF_W] * w_mb[VAL_W-1:HALF_W];
            r_neg1 <= w_ua[VAL_W-1] ^ w_ub[VAL_W-1];
            r_mag  <= w_full[PROD_W-1:FRAC_BITS];
            r_neg2 <= r_neg1;
            r_p    <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

### rtl/lpb_lane.sv
// One axis lane: evaluates the selected polynomial factor of one coordinate in nested form.
module lpb_lane (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [lpb_pkg::ORDER_W-1:0]        i_order,
    input  logic signed [lpb_pkg::COORD_W-1:0] i_coord,
    output lpb_pkg::t_val                      o_factor
);
    import lpb_pkg::*;

    t_coef                     w_coef;
    logic signed [COORD_W-1:0] r_x [X_TAPS];
    t_val                      w_xe;
    t_val                      w_sq;
    t_val                      r_s0;
    t_val                      r_t0;
    t_val                      stage_t [N_STEPS+1];
    t_val                      stage_s [N_STEPS];
    t_val                      w_xt;
    t_val                      w_px;
    t_val                      r_tx [FMUL_LAT];
    t_val                      w_sc_in;
    t_val                      w_ps;
    t_val                      r_f;

    assign w_coef = get_coef(i_order);
    assign w_xe   = t_val'(i_coord);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= i_coord;
            for (int i = 1; i < X_TAPS; i++) begin
                r_x[i] <= r_x[i-1];
            end
        end
    end

    lpb_fmul u_sq (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_xe),
        .i_b   (w_xe),
        .o_p   (w_sq)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0 <= w_sq;
            r_t0 <= sat_add(w_sq, w_coef.k0);
        end
    end

    assign stage_t[0] = r_t0;
    assign stage_s[0] = r_s0;

    for (genvar g = 0; g < N_STEPS; g++) begin : g_step
        t_val w_p;
        t_val r_td [FMUL_LAT];
        t_val r_tn;

        lpb_fmul u_mul (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (stage_s[g]),
            .i_b   (stage_t[g]),
            .o_p   (w_p)
        );

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_td[0] <= stage_t[g];
                for (int k = 1; k < FMUL_LAT; k++) begin
                    r_td[k] <= r_td[k-1];
                end
                r_tn <= (w_coef.nmul > N_MUL_W'(g)) ? sat_add(w_p, w_coef.k[g])
                                                    : r_td[FMUL_LAT-1];
            end
        end

        assign stage_t[g+1] = r_tn;

        if (g < N_STEPS - 1) begin : g_s
            t_val r_sd [FMUL_LAT];
            t_val r_sn;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sd[0] <= stage_s[g];
                    for (int k = 1; k < FMUL_LAT; k++) begin
                        r_sd[k] <= r_sd[k-1];
                    end
                    r_sn <= r_sd[FMUL_LAT-1];
                end
            end

            assign stage_s[g+1] = r_sn;
        end
    end

    assign w_xt = t_val'(r_x[XMUL_TAP]);

    lpb_fmul u_xm (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (stage_t[N_STEPS]),
        .i_b   (w_xt),
        .o_p   (w_px)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx[0] <= stage_t[N_STEPS];
            for (int k = 1; k < FMUL_LAT; k++) begin
                r_tx[k] <= r_tx[k-1];
            end
        end
    end

    assign w_sc_in = w_coef.odd ? w_px : r_tx[FMUL_LAT-1];

    lpb_fmul u_sc (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_sc_in),
        .i_b   (w_coef.scale),
        .o_p   (w_ps)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (w_coef.kind)
                KIND_ONE:  r_f <= VAL_ONE;
                KIND_LIN:  r_f <= t_val'(r_x[X_TAPS-1]);
                KIND_POLY: r_f <= w_ps;
                default:   r_f <= VAL_ONE;
            endcase
        end
    end

    assign o_factor = r_f;
endmodule

### rtl/lpb_merge.sv
// Merging stage: multiplies the three lane factors into the basis value.
module lpb_merge (
    input  logic          i_clk,
    input  logic          i_en,
    input  lpb_pkg::t_val i_fx,
    input  lpb_pkg::t_val i_fy,
    input  lpb_pkg::t_val i_fz,
    output lpb_pkg::t_val o_value
);
    import lpb_pkg::*;

    t_val w_pxy;
    t_val r_fz [FMUL_LAT];

    lpb_fmul u_xy (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_fx),
        .i_b   (i_fy),
        .o_p   (w_pxy)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fz[0] <= i_fz;
            for (int k = 1; k < FMUL_LAT; k++) begin
                r_fz[k] <= r_fz[k-1];
            end
        end
    end

    lpb_fmul u_xyz (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_pxy),
        .i_b   (r_fz[FMUL_LAT-1]),
        .o_p   (o_value)
    );
endmodule

### rtl/legendre_product_basis_eval_unit.sv
// Top level of the tensor-product Legendre basis unit: config registers, lanes, merge and output.
// An accepted input beat passes through the lanes and the merge stage into the output register.
// Throughput is one beat per cycle; three lanes and the merge multipliers are fully pipelined.
// The pipeline stalls only when its last stage holds a result and the output register holds
// a beat that is not being taken.
// Reset clears the three order registers to zero, all stage valid bits and the output valid.
module legendre_product_basis_eval_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lpb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lpb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lpb_in_if.sink                           i_pt,
    lpb_out_if.source                        o_res
);
    import lpb_pkg::*;

    logic [ORDER_W-1:0]    r_order_x;
    logic [ORDER_W-1:0]    r_order_y;
    logic [ORDER_W-1:0]    r_order_z;
    logic                  w_en;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] r_last;
    t_val                  w_fx;
    t_val                  w_fy;
    t_val                  w_fz;
    t_val                  w_value;
    logic                  r_out_valid;
    t_val                  r_out_value;
    logic                  r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_x <= '0;
            r_order_y <= '0;
            r_order_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORDER_X: r_order_x <= i_cfg_data;
                REG_ORDER_Y: r_order_y <= i_cfg_data;
                REG_ORDER_Z: r_order_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en       = !r_vld[PIPE_DEPTH-1] || !r_out_valid || o_res.ready;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_pt.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last <= {r_last[PIPE_DEPTH-2:0], i_pt.last_in};
        end
    end

    lpb_lane u_lane_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_order  (r_order_x),
        .i_coord  (i_pt.coord_x),
        .o_factor (w_fx)
    );

    lpb_lane u_lane_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_order  (r_order_y),
        .i_coord  (i_pt.coord_y),
        .o_factor (w_fy)
    );

    lpb_lane u_lane_z (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_order  (r_order_z),
        .i_coord  (i_pt.coord_z),
        .o_factor (w_fz)
    );

    lpb_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_fx    (w_fx),
        .i_fy    (w_fy),
        .i_fz    (w_fz),
        .o_value (w_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en && r_vld[PIPE_DEPTH-1]) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[PIPE_DEPTH-1]) begin
            r_out_value <= w_value;
            r_out_last  <= r_last[PIPE_DEPTH-1];
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.basis_value = r_out_value;
    assign o_res.last_out    = r_out_last;

    // An accepted beat always enters the first pipeline stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.valid && i_pt.ready |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    // A finished result blocked at the output must still be held next cycle.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_DEPTH-1] && r_out_valid && !o_res.ready |=>
        r_vld[PIPE_DEPTH-1] && r_out_valid)
        else $error("result lost while the output was stalled");

    // The output register is only filled from a valid last pipeline stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vld[PIPE_DEPTH-1]))
        else $error("output became valid without a finished result");
endmodule

### sim/testbench.sv
// Self-checking testbench for the tensor-product Legendre basis unit.
`timescale 1ns / 1ps

module testbench;
    import lpb_pkg::*;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct {
        t_val value;
        logic last;
    } t_basis_beat;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_PHASES = 24;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int FLUSH_CYCLES = 40;

    class basis_checker;
        logic [ORDER_W-1:0] order_x;
        logic [ORDER_W-1:0] order_y;
        logic [ORDER_W-1:0] order_z;
        t_basis_beat expected_basis[$];
        int unsigned errors;
        int unsigned points;
        int unsigned results;
        int unsigned saturated;
        int unsigned settings;

        function new();
            order_x = '0;
            order_y = '0;
            order_z = '0;
            errors = 0;
            points = 0;
            results = 0;
            saturated = 0;
            settings = 0;
        endfunction

        function void set_order(logic [CFG_IDX_W-1:0] idx, logic [ORDER_W-1:0] value);
            case (idx)
                REG_ORDER_X: order_x = value;
                REG_ORDER_Y: order_y = value;
                REG_ORDER_Z: order_z = value;
                default: ;
            endcase
        endfunction

        function longint fx(longint n, longint d);
            return ((n << FRAC_BITS) * 2 + d) / (2 * d);
        endfunction

        function longint clamp48(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) << (VAL_W - 1)) - 1;
            lo = -(longint'(1) << (VAL_W - 1));
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Exact product, rounded half away from zero, then clamped to 48 bits.
        function longint mul_round(longint a, longint b);
            logic         neg;
            logic [63:0]  ua;
            logic [63:0]  ub;
            logic [127:0] p;
            logic [127:0] mag;
            logic [127:0] lim;
            lim = 128'd1 << (VAL_W - 1);
            neg = (a < 0) != (b < 0);
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            p = ua * ub;
            mag = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (mag > lim) mag = lim;
            if (neg) return -longint'(mag[63:0]);
            if (mag > lim - 1) mag = lim - 1;
            return longint'(mag[63:0]);
        endfunction

        function longint axis_factor(logic [ORDER_W-1:0] ord, longint x);
            longint s;
            longint v;
            longint scale;
            longint k[4];
            s = mul_round(x, x);
            k = '{0, 0, 0, 0};
            case (ord)
                4'd1: return x;
                4'd2: begin
                    k[0] = -fx(3333333, 10000000);
                    scale = fx(1, 1);
                end
                4'd3: begin
                    k[0] = -fx(6, 10);
                    scale = fx(3, 2);
                end
                4'd4: begin
                    k[0] = -fx(857143, 1000000);
                    k[1] = fx(857143, 10000000);
                    scale = fx(2, 1);
                end
                4'd5: begin
                    k[0] = -fx(111111, 100000);
                    k[1] = fx(238095, 1000000);
                    scale = fx(3, 1);
                end
                4'd6: begin
                    k[0] = -fx(136364, 100000);
                    k[1] = fx(454545, 1000000);
                    k[2] = -fx(21645, 1000000);
                    scale = fx(6, 1);
                end
                4'd7: begin
                    k[0] = -fx(161538, 100000);
                    k[1] = fx(734266, 1000000);
                    k[2] = -fx(81585, 1000000);
                    scale = fx(10, 1);
                end
                4'd8: begin
                    k[0] = -fx(186667, 100000);
                    k[1] = fx(107692, 100000);
                    k[2] = -fx(195804, 1000000);
                    k[3] = fx(54390, 10000000);
                    scale = fx(18, 1);
                end
                4'd9: begin
                    k[0] = -fx(211765, 100000);
                    k[1] = fx(148235, 100000);
                    k[2] = -fx(380090, 1000000);
                    k[3] = fx(259153, 10000000);
                    scale = fx(32, 1);
                end
                default: return longint'(1) << FRAC_BITS;
            endcase
            v = clamp48(s + k[0]);
            for (int i = 1; i < int'(ord) / 2; i++) begin
                v = clamp48(mul_round(s, v) + k[i]);
            end
            if (ord[0]) v = mul_round(v, x);
            return mul_round(v, scale);
        endfunction

        function void note_point(t_coord x, t_coord y, t_coord z, logic last);
            t_basis_beat b;
            longint v;
            v = axis_factor(order_x, longint'(x));
            v = mul_round(v, axis_factor(order_y, longint'(y)));
            v = mul_round(v, axis_factor(order_z, longint'(z)));
            b.value = t_val'(v);
            b.last = last;
            expected_basis.push_back(b);
            points++;
        endfunction

        function void check_result(t_val value, logic last);
            t_basis_beat b;
            if (expected_basis.size() == 0) begin
                $error("unexpected result beat: basis_value %0d last_out %0b", value, last);
                errors++;
                return;
            end
            b = expected_basis.pop_front();
            results++;
            if (b.value == VAL_MAX || b.value == VAL_MIN) saturated++;
            if (value !== b.value) begin
                $error("basis_value: expected %0d, got %0d", b.value, value);
                errors++;
            end
            if (last !== b.last) begin
                $error("last_out: expected %0b, got %0b", b.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_basis.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lpb_in_if  pt_if();
    lpb_out_if res_if();

    legendre_product_basis_eval_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if),
        .o_res      (res_if)
    );

    basis_checker sb;
    int quiet_cycles = 0;
    int ready_mode = 0;
    int mode_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (pt_if.valid && pt_if.ready) begin
            sb.note_point(pt_if.coord_x, pt_if.coord_y, pt_if.coord_z, pt_if.last_in);
        end
        if (res_if.valid && res_if.ready) begin
            sb.check_result(res_if.basis_value, res_if.last_out);
        end
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The receiver switches between always ready, half-rate and heavy stalls.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(32, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= 1'($urandom_range(0, 1));
                default: res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Watchdog expired after %0d idle cycles.", WATCHDOG_LIMIT);
        $display("FAIL legendre_product_basis_eval_unit");
        $finish;
    end

    task automatic send_point(input int x, input int y, input int z, input logic last);
        pt_if.valid <= 1'b1;
        pt_if.coord_x <= t_coord'(x);
        pt_if.coord_y <= t_coord'(y);
        pt_if.coord_z <= t_coord'(z);
        pt_if.last_in <= last;
        do @(posedge i_clk); while (!pt_if.ready);
    endtask

    task automatic hold_sender(input int cycles);
        pt_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic program_orders(input logic [ORDER_W-1:0] ox, input logic [ORDER_W-1:0] oy,
                                  input logic [ORDER_W-1:0] oz, input logic [ORDER_W-1:0] spare);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [ORDER_W-1:0]   val[4];
        idx = '{REG_ORDER_X, REG_ORDER_Y, REG_ORDER_Z, REG_SPARE};
        val = '{ox, oy, oz, spare};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[i];
            i_cfg_data <= val[i];
            @(posedge i_clk);
            sb.set_order(idx[i], val[i]);
        end
        i_cfg_we <= 1'b0;
        sb.settings++;
    endtask

    function automatic int rand_coord();
        int pick;
        int specials[5];
        specials = '{0, 65536, -65536, 524287, -524288};
        pick = $urandom_range(0, 9);
        if (pick <= 5) return int'($urandom_range(0, 131072)) - 65536;
        if (pick <= 7) return int'($urandom_range(0, 524288)) - 262144;
        if (pick == 8) return int'(t_coord'($urandom));
        return specials[$urandom_range(0, 4)];
    endfunction

    function automatic logic [ORDER_W-1:0] pick_order();
        if ($urandom_range(0, 6) == 0) return ORDER_W'($urandom_range(10, 15));
        return ORDER_W'($urandom_range(0, 9));
    endfunction

    initial begin
        int burst_left;
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pt_if.valid = 1'b0;
        pt_if.coord_x = '0;
        pt_if.coord_y = '0;
        pt_if.coord_z = '0;
        pt_if.last_in = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Highest orders with coordinates at the nominal and 20-bit limits.
        program_orders(4'd9, 4'd8, 4'd7, 4'd15);
        send_point(0, 0, 0, 1'b0);
        send_point(65536, 65536, 65536, 1'b1);
        send_point(-65536, -65536, -65536, 1'b0);
        send_point(524287, 524287, 524287, 1'b0);
        send_point(-524288, -524288, -524288, 1'b1);
        send_point(262144, -262144, 262144, 1'b0);
        send_point(-262144, 262144, -262144, 1'b0);
        send_point(1, -1, 32768, 1'b0);
        send_point(-32768, 21845, -43690, 1'b1);
        hold_sender(0);
        drain_results();

        program_orders(4'd1, 4'd2, 4'd3, 4'd0);
        send_point(524287, -524288, 65536, 1'b0);
        send_point(-524288, 524287, -65536, 1'b1);
        send_point(0, 0, 0, 1'b0);
        send_point(39321, -39321, 12345, 1'b0);
        hold_sender(0);
        drain_results();

        program_orders(4'd4, 4'd5, 4'd6, 4'd9);
        send_point(65536, -65536, 524287, 1'b0);
        send_point(-524288, 0, -52428, 1'b1);
        send_point(30000, -30000, 60000, 1'b0);
        hold_sender(0);
        drain_results();

        // Unused order codes must act as a constant factor of one.
        program_orders(4'd10, 4'd15, 4'd0, 4'd2);
        send_point(524287, -524288, 12345, 1'b1);
        send_point(0, 0, 0, 1'b0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            hold_sender(0);
            drain_results();
            program_orders(pick_order(), pick_order(), pick_order(), ORDER_W'($urandom));
            burst_left = 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (ph == N_PHASES / 2 && i == ITEMS_PER_PHASE / 2) begin
                    hold_sender(0);
                    drain_results();
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    if (ph % 4 != 3 && $urandom_range(0, 3) != 0) begin
                        hold_sender($urandom_range(1, 6));
                    end
                end
                send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 7) == 0);
                burst_left--;
            end
        end

        hold_sender(0);
        drain_results();
        repeat (FLUSH_CYCLES) @(posedge i_clk);

        $display("Checked %0d basis values from %0d points over %0d order settings.",
                 sb.results, sb.points, sb.settings);
        $display("%0d of them clamped at the 48-bit limits; %0d mismatches found.",
                 sb.saturated, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS legendre_product_basis_eval_unit");
        end else begin
            $display("FAIL legendre_product_basis_eval_unit");
        end
        $finish;
    end

endmodule
